@@ rtl/cdoy_pkg.sv @@
// ----------------------------------------------------------------------------
// cdoy_pkg
// Types, codes and constant tables shared by the day-of-year converter.
// ----------------------------------------------------------------------------
package cdoy_pkg;

  // Request beat
  typedef struct packed {
    logic        kind;
    logic [13:0] year_value;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [8:0]  yearday_in;
  } req_t;

  // Response beat
  typedef struct packed {
    logic [1:0] status;
    logic [8:0] yearday_out;
    logic [3:0] month_out;
    logic [4:0] day_out;
  } rsp_t;

  // Conversion direction
  localparam logic KIND_MD_TO_YD = 1'b0;
  localparam logic KIND_YD_TO_MD = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_MONTH   = 2'd1;
  localparam logic [1:0] ST_BAD_DAY     = 2'd2;
  localparam logic [1:0] ST_BAD_YEARDAY = 2'd3;

  // Month bounds
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Year lengths
  localparam logic [8:0] DAYS_COMMON = 9'd365;
  localparam logic [8:0] DAYS_LEAP   = 9'd366;

  // Divisibility by 25 on a 14-bit year: multiply by the inverse of 25
  // modulo 2^14; the year is a multiple of 25 exactly when the low 14 bits
  // of the product do not exceed (2^14 - 1) / 25.
  localparam logic [13:0] DIV25_INV   = 14'd7209;
  localparam logic [13:0] DIV25_LIMIT = 14'd655;

  // Month lengths in a common year, indexed by month; unused codes are zero
  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
  };

  // Days before the first of each month in a common year
  localparam logic [8:0] CUM_BEFORE [16] = '{
    9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0,   9'd0,   9'd0
  };

  // Length of a month, with the leap day added to February
  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
    month_days = MONTH_LEN[month] + {4'd0, (leap && (month == MONTH_FEB))};
  endfunction

  // Days before the first of a month, with the leap day counted after February
  function automatic logic [8:0] days_before(input logic leap, input logic [3:0] month);
    days_before = CUM_BEFORE[month] + {8'd0, (leap && (month > MONTH_FEB))};
  endfunction

endpackage

@@ rtl/cdoy_month_search.sv @@
// ----------------------------------------------------------------------------
// cdoy_month_search
// Finds the month that holds a given day of the year by comparing it with
// the end of every month but the last, all in parallel.
// ----------------------------------------------------------------------------
module cdoy_month_search (
  input  logic       leap,
  input  logic [8:0] yearday,
  output logic [3:0] month
);
  import cdoy_pkg::*;

  logic [10:0] past_end;

  // Flag every month whose last day lies before the day asked for
  always_comb begin
    for (int i = 0; i < 11; i++) begin
      past_end[i] = (yearday > days_before(leap, 4'(i + 2)));
    end
  end

  // Month ends rise with the month, so the flag count names the month
  always_comb begin
    month = MONTH_JAN;
    for (int i = 0; i < 11; i++) begin
      month = month + {3'd0, past_end[i]};
    end
  end

endmodule

@@ rtl/calendar_day_of_year_converter.sv @@
// ----------------------------------------------------------------------------
// calendar_day_of_year_converter
// Gregorian date to day-of-year conversion, both directions, with status.
// ----------------------------------------------------------------------------
// The block takes one request beat per cycle while req_ready is high and
// returns one response beat per request, in order. An accepted request
// reaches the response port through four register stages: the year is
// multiplied for the century test, the leap flag is formed, the month table is
// looked up and the yearday sum or month search is done, and finally the day of
// month is subtracted out. Each stage holds when the one after it is full and
// stalled, so back-pressure on the response port ripples back to req_ready
// without dropping or repeating a beat.
module calendar_day_of_year_converter (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  cdoy_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output cdoy_pkg::rsp_t rsp
);
  import cdoy_pkg::*;

  // Stage valid bits and advance enables
  logic v1, v2, v3;
  logic en1, en2, en3, en4;

  // Stage 1: request and century product
  req_t        s1_req;
  logic [13:0] s1_prod;
  logic [27:0] year_mul;

  // Stage 2: request and leap flag
  req_t s2_req;
  logic s2_leap;

  // Stage 3: partial result
  logic       s3_kind;
  logic       s3_leap;
  logic [1:0] s3_status;
  logic [8:0] s3_yearday;
  logic [3:0] s3_month;
  logic [8:0] s3_yd_in;

  // Combinational results
  logic       leap_next;
  logic [1:0] status_next;
  logic [8:0] yearday_next;
  logic [3:0] month_next;
  logic [3:0] found_month;
  logic [8:0] year_limit;
  logic [8:0] day_left;
  rsp_t       rsp_next;

  // Advance a stage when the one after it is empty or moving
  assign en4       = !rsp_valid || rsp_ready;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_ready = en1;

  // Track valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) rsp_valid <= v3;
    end
  end

  // Stage 1: multiply the year by the inverse of 25
  assign year_mul = 28'(req.year_value) * 28'(DIV25_INV);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_req  <= req;
      s1_prod <= year_mul[13:0];
    end
  end

  // Stage 2: leap when divisible by 4, and either not by 25 or also by 16
  assign leap_next = (s1_req.year_value[1:0] == 2'd0) &&
                     ((s1_prod > DIV25_LIMIT) || (s1_req.year_value[3:0] == 4'd0));

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_req  <= s1_req;
      s2_leap <= leap_next;
    end
  end

  // Stage 3: range checks, yearday sum and month search
  cdoy_month_search u_month_search (
    .leap    (s2_leap),
    .yearday (s2_req.yearday_in),
    .month   (found_month)
  );

  assign year_limit = s2_leap ? DAYS_LEAP : DAYS_COMMON;

  always_comb begin
    status_next  = ST_OK;
    yearday_next = '0;
    month_next   = '0;
    if (s2_req.kind == KIND_MD_TO_YD) begin
      if ((s2_req.month_in < MONTH_JAN) || (s2_req.month_in > MONTH_DEC)) begin
        status_next = ST_BAD_MONTH;
      end else if ((s2_req.day_in == 5'd0) ||
                   (s2_req.day_in > month_days(s2_leap, s2_req.month_in))) begin
        status_next = ST_BAD_DAY;
      end else begin
        yearday_next = days_before(s2_leap, s2_req.month_in) + {4'd0, s2_req.day_in};
      end
    end else begin
      if ((s2_req.yearday_in == 9'd0) || (s2_req.yearday_in > year_limit)) begin
        status_next = ST_BAD_YEARDAY;
      end else begin
        month_next = found_month;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_kind    <= s2_req.kind;
      s3_leap    <= s2_leap;
      s3_status  <= status_next;
      s3_yearday <= yearday_next;
      s3_month   <= month_next;
      s3_yd_in   <= s2_req.yearday_in;
    end
  end

  // Stage 4: take the days before the month off to get the day of month
  assign day_left = s3_yd_in - days_before(s3_leap, s3_month);

  always_comb begin
    rsp_next.status      = s3_status;
    rsp_next.yearday_out = s3_yearday;
    rsp_next.month_out   = s3_month;
    rsp_next.day_out     = '0;
    if ((s3_kind == KIND_YD_TO_MD) && (s3_status == ST_OK)) begin
      rsp_next.day_out = day_left[4:0];
    end
  end

  // Hold the response beat until it is taken
  always_ff @(posedge clk) begin
    if (en4) begin
      rsp <= rsp_next;
    end
  end

endmodule
